// ----- hw/rtl/mf3_pkg.sv -----
// ---------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types of the 3x3 maximum filter.
// ---------------------------------------------------------------------------
package mf3_pkg;

  // window side length
  localparam int unsigned Win = 3;

  // configuration register map (word index)
  localparam logic RegImageSize = 1'b0;

  localparam int unsigned ImageSizeBits = 8;
  localparam logic [ImageSizeBits-1:0] ImageSizeRst = 8'd128;
  localparam logic [ImageSizeBits-1:0] ImageSizeMin = 8'd3;

  // tag that travels with a window toward the output register
  typedef struct packed {
    logic emit;
    logic row_end;
    logic frame_end;
  } mf3_tag_t;

endpackage

// ----- hw/rtl/max_filter_3x3.sv -----
// ---------------------------------------------------------------------------
// max_filter_3x3
// Valid-region 3x3 maximum (grey dilation) over a streamed square image.
// ---------------------------------------------------------------------------
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------
//   pixel in | input     | in_valid_i/in_stall_o | pixel_value_i
//   result   | output    | out_valid_o/out_stall_i| local_max_o, row_end_o,
//            |           |                       | frame_end_o
//   config   | input     | apb psel/penable      | image_size at byte 0
//
// One pixel per clock. Both line buffers share one RAM whose read address
// runs one pixel ahead of the column counter, so the previous rows' pixels
// are ready when the next beat arrives. A result passes through the window
// register, then the output register. Reset clears the counters, window and
// control; the RAM contents are not cleared. Input stalls only while a result
// waits in the window stage behind a stalled output register.
// ---------------------------------------------------------------------------
module max_filter_3x3 #(
  parameter int unsigned MAX_SIZE   = 128,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // apb configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_BITS-1:0] pixel_value_i,
  // result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIXEL_BITS-1:0] local_max_o,
  output logic                  row_end_o,
  output logic                  frame_end_o
);
  import mf3_pkg::*;

  localparam int unsigned CntBits  = $clog2(MAX_SIZE);
  localparam int unsigned SideBits =
      (CntBits + 1 > ImageSizeBits) ? CntBits + 1 : ImageSizeBits;
  localparam logic [SideBits-1:0] MaxSide = SideBits'(MAX_SIZE);

  // configuration
  logic [ImageSizeBits-1:0] image_size_q;
  logic                     reg_sel;

  assign reg_sel = (paddr[2] == RegImageSize);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(image_size_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= ImageSizeRst;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      image_size_q <= pwdata[ImageSizeBits-1:0];
    end
  end

  // side length, clamped to the supported range
  logic [SideBits-1:0] side_raw;
  logic [SideBits-1:0] side;

  assign side_raw = SideBits'(image_size_q);

  always_comb begin
    if (image_size_q < ImageSizeMin) begin
      side = SideBits'(ImageSizeMin);
    end else if (side_raw > MaxSide) begin
      side = MaxSide;
    end else begin
      side = side_raw;
    end
  end

  // handshake
  mf3_tag_t tag_q, tag_d;
  logic     out_valid_q;
  logic     tag_move;
  logic     accept;

  assign tag_move   = tag_q.emit && (!out_valid_q || !out_stall_i);
  assign in_stall_o = tag_q.emit && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // position counters
  logic [CntBits-1:0] col_q, col_d;
  logic [CntBits-1:0] row_q, row_d;
  logic               last_col;
  logic               last_row;
  logic               emit;

  assign last_col = (SideBits'(col_q) + SideBits'(1)) >= side;
  assign last_row = (SideBits'(row_q) + SideBits'(1)) >= side;
  assign emit     = (row_q >= CntBits'(2)) && (col_q >= CntBits'(2)) &&
                    (SideBits'(row_q) < side) && (SideBits'(col_q) < side);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + CntBits'(1);
      end else begin
        col_d = col_q + CntBits'(1);
      end
    end
  end

  // line buffers: {row above previous, previous row} per column
  logic [2*PIXEL_BITS-1:0] lb_wdata;
  logic [2*PIXEL_BITS-1:0] lb_rdata;
  logic [PIXEL_BITS-1:0]   top_px;
  logic [PIXEL_BITS-1:0]   mid_px;

  assign top_px   = lb_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid_px   = lb_rdata[PIXEL_BITS-1:0];
  assign lb_wdata = {mid_px, pixel_value_i};

  // read address looks one beat ahead so data is ready back to back
  mf3_ram #(
    .Width (2 * PIXEL_BITS),
    .Depth (MAX_SIZE)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (lb_wdata),
    .raddr_i (col_d),
    .rdata_o (lb_rdata)
  );

  // 3x3 window, column 2 is the newest
  logic [PIXEL_BITS-1:0] win_q [Win][Win];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      for (int r = 0; r < Win; r++) begin
        for (int c = 0; c < Win; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
      for (int r = 0; r < Win; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top_px;
      win_q[1][2] <= mid_px;
      win_q[2][2] <= pixel_value_i;
    end
  end

  always_comb begin
    tag_d = tag_q;
    if (accept) begin
      tag_d.emit      = emit;
      tag_d.row_end   = last_col;
      tag_d.frame_end = last_col && last_row;
    end else if (tag_move) begin
      tag_d.emit = 1'b0;
    end
  end

  // maximum of the window
  logic [PIXEL_BITS-1:0] win_max;

  always_comb begin
    win_max = '0;
    for (int r = 0; r < Win; r++) begin
      for (int c = 0; c < Win; c++) begin
        if (win_q[r][c] > win_max) begin
          win_max = win_q[r][c];
        end
      end
    end
  end

  // output register
  logic [PIXEL_BITS-1:0] local_max_q;
  logic                  row_end_q;
  logic                  frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tag_q <= tag_d;
      if (tag_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_move) begin
      local_max_q <= win_max;
      row_end_q   <= tag_q.row_end;
      frame_end_q <= tag_q.frame_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign local_max_o = local_max_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

// ----- hw/rtl/mf3_ram.sv -----
// ---------------------------------------------------------------------------
// mf3_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module mf3_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- dv/tb_max_filter_3x3.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_max_filter_3x3
// Self-checking bench for the 3x3 maximum filter. Square frames of pixels are
// streamed at many side lengths, including the clamped extremes and shrinks in
// the middle of a frame. The sender idles in bursts and the receiver stalls,
// once for a long hold-off. Every result beat is compared with a line-buffer
// and window model kept in the bench.
// ---------------------------------------------------------------------------
module tb_max_filter_3x3;
  import mf3_pkg::*;

  localparam int unsigned MaxSize     = 128;
  localparam int unsigned PixBits     = 8;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned RandomBeats = 300;
  localparam logic [2:0]  ImageSizeAddr = {RegImageSize, 2'b00};

  typedef enum int unsigned {PixUniform, PixDark, PixBright, PixExtreme} pix_style_e;
  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallPeriodic} stall_mode_e;

  typedef struct packed {
    logic [PixBits-1:0] peak;
    logic               row_last;
    logic               frame_last;
  } max_beat_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [2:0]         paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [PixBits-1:0] pixel     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PixBits-1:0] local_max;
  logic               row_end;
  logic               frame_end;

  max_filter_3x3 u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pixel_value_i (pixel),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .local_max_o   (local_max),
    .row_end_o     (row_end),
    .frame_end_o   (frame_end)
  );

  always #5 clk = ~clk;

  // dilation model state
  logic [PixBits-1:0] line_prev  [MaxSize];
  logic [PixBits-1:0] line_older [MaxSize];
  logic [PixBits-1:0] win_q      [Win][Win];
  int unsigned        col_cnt;
  int unsigned        row_cnt;
  logic [7:0]         size_cfg;
  max_beat_t          pending_max_q [$];

  int unsigned mismatch_cnt = 0;
  int unsigned burst_left   = 0;
  bit          gaps_on      = 1'b0;

  // receiver stall pattern
  stall_mode_e stall_mode  = StallNone;
  int unsigned mode_left   = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_reqs   = 0;
  int unsigned stall_phase = 0;

  function automatic void flag_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endfunction

  function automatic int unsigned side_len(input logic [7:0] value);
    if (value < ImageSizeMin) return ImageSizeMin;
    if (value > MaxSize) return MaxSize;
    return value;
  endfunction

  function automatic void predictor_clear();
    int unsigned i;
    int unsigned j;
    for (i = 0; i < MaxSize; i++) begin
      line_prev[i]  = '0;
      line_older[i] = '0;
    end
    for (i = 0; i < Win; i++) begin
      for (j = 0; j < Win; j++) begin
        win_q[i][j] = '0;
      end
    end
    col_cnt  = 0;
    row_cnt  = 0;
    size_cfg = ImageSizeRst;
  endfunction

  function automatic void dilate_pixel(input logic [PixBits-1:0] px);
    int unsigned        n;
    int unsigned        r;
    int unsigned        c;
    logic [PixBits-1:0] top;
    logic [PixBits-1:0] mid;
    logic               last_col;
    logic               last_row;
    max_beat_t          beat;
    n        = side_len(size_cfg);
    last_col = (col_cnt + 1 >= n);
    last_row = (row_cnt + 1 >= n);
    top      = '0;
    mid      = '0;
    if (col_cnt < MaxSize) begin
      top = line_older[col_cnt];
      mid = line_prev[col_cnt];
      line_older[col_cnt] = mid;
      line_prev[col_cnt]  = px;
    end
    for (r = 0; r < Win; r++) begin
      win_q[r][0] = win_q[r][1];
      win_q[r][1] = win_q[r][2];
    end
    win_q[0][2] = top;
    win_q[1][2] = mid;
    win_q[2][2] = px;
    if (row_cnt >= 2 && col_cnt >= 2 && row_cnt < n && col_cnt < n) begin
      beat.peak = '0;
      for (r = 0; r < Win; r++) begin
        for (c = 0; c < Win; c++) begin
          if (win_q[r][c] > beat.peak) beat.peak = win_q[r][c];
        end
      end
      beat.row_last   = last_col;
      beat.frame_last = last_col && last_row;
      pending_max_q.push_back(beat);
    end
    if (last_col) begin
      col_cnt = 0;
      row_cnt = last_row ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
  endfunction

  // pixels still to come before the counters wrap to a new frame
  function automatic int unsigned pixels_to_frame_end();
    int unsigned n;
    int unsigned rest;
    n    = side_len(size_cfg);
    rest = (col_cnt + 1 >= n) ? 1 : n - col_cnt;
    if (row_cnt + 1 < n) rest += (n - 1 - row_cnt) * n;
    return rest;
  endfunction

  task automatic send_pixel(input logic [PixBits-1:0] px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pixel    <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dilate_pixel(px);
  endtask

  task automatic send_pixels(input int unsigned count, input pix_style_e style);
    logic [PixBits-1:0] px;
    repeat (count) begin
      case (style)
        PixDark: begin
          px = ($urandom_range(0, 15) == 0) ? PixBits'($urandom)
                                            : PixBits'($urandom_range(0, 15));
        end
        PixBright:  px = PixBits'($urandom_range(240, 255));
        PixExtreme: px = $urandom_range(0, 1) ? '1 : '0;
        default:    px = PixBits'($urandom);
      endcase
      send_pixel(px);
    end
  endtask

  // setup and access phase; the bus is released only after the last access
  task automatic apb_access(input logic wr, input logic [31:0] wdata, input logic last,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ImageSizeAddr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (last) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    in_valid  <= 1'b0;
    burst_left = 0;
    while (pending_max_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_image_size(input logic [7:0] value);
    logic [31:0] rd;
    wait_drained();
    apb_access(1'b1, 32'(value), 1'b0, rd);
    apb_access(1'b0, '0, 1'b1, rd);
    if (rd[ImageSizeBits-1:0] !== value) begin
      flag_mismatch("image_size readback", value, rd[ImageSizeBits-1:0]);
    end
    size_cfg = value;
  endtask

  task automatic test_directed_windows();
    logic [31:0] rd;
    int unsigned k;
    apb_access(1'b0, '0, 1'b1, rd);
    if (rd[ImageSizeBits-1:0] !== ImageSizeRst) begin
      flag_mismatch("image_size after reset", ImageSizeRst, rd[ImageSizeBits-1:0]);
    end
    gaps_on = 1'b0;
    set_image_size(ImageSizeMin);
    repeat (9) send_pixel('0);
    repeat (9) send_pixel('1);
    // side length below the minimum runs as the minimum
    set_image_size(8'd1);
    for (k = 0; k < PixBits; k++) send_pixel(PixBits'(1 << k));
    send_pixel(8'h7f);
  endtask

  task automatic test_size_extremes();
    gaps_on = 1'b1;
    set_image_size(8'd128);
    send_pixels(3 * MaxSize, PixUniform);
    // row counter ends up past the new side length
    set_image_size(ImageSizeMin);
    send_pixels(pixels_to_frame_end(), PixUniform);
    // above the maximum clamps to the maximum
    set_image_size(8'd255);
    send_pixels(2 * MaxSize + 51, PixDark);
    // column counter ends up past the new side length
    set_image_size(8'd20);
    send_pixels(pixels_to_frame_end(), PixBright);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    set_image_size(8'd16);
    hold_reqs++;
    send_pixels(16 * 16, PixUniform);
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned n;
    int unsigned pick;
    int unsigned total;
    int unsigned cut;
    int unsigned rest;
    pix_style_e  style;
    sent = 0;
    while (sent < RandomBeats) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) n = $urandom_range(3, 10);
      else if (pick < 85) n = $urandom_range(11, 24);
      else if (pick < 95) n = $urandom_range(25, 48);
      else n = $urandom_range(0, 2);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (side_len(8'(n)) != side_len(size_cfg) || $urandom_range(0, 3) == 0) begin
        set_image_size(8'(n));
      end
      style = pix_style_e'($urandom_range(0, 3));
      total = pixels_to_frame_end();
      if (side_len(size_cfg) > ImageSizeMin && $urandom_range(0, 5) == 0) begin
        // shrink partway through the frame; every column still in use was written
        cut = $urandom_range(1, total - 1);
        send_pixels(cut, style);
        set_image_size(8'($urandom_range(0, side_len(size_cfg) - 1)));
        rest = pixels_to_frame_end();
        send_pixels(rest, style);
        sent += cut + rest;
      end else begin
        send_pixels(total, style);
        sent += total;
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HoldCycles;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end
    mode_left--;
    stall_phase++;
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        StallNone:  out_stall <= 1'b0;
        StallLight: out_stall <= ($urandom_range(0, 3) == 0);
        StallHeavy: out_stall <= ($urandom_range(0, 1) == 0);
        default:    out_stall <= (stall_phase % 7 < 3);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    max_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_max_q.size() == 0) begin
        flag_mismatch("result beat with nothing pending, local_max", 0, local_max);
      end else begin
        want = pending_max_q.pop_front();
        if (local_max !== want.peak) flag_mismatch("local_max", want.peak, local_max);
        if (row_end !== want.row_last) flag_mismatch("row_end", want.row_last, row_end);
        if (frame_end !== want.frame_last) begin
          flag_mismatch("frame_end", want.frame_last, frame_end);
        end
      end
    end
  end

  initial begin
    predictor_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_windows();
    test_size_extremes();
    test_backpressure();
    test_random_frames();
    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- max_filter_3x3.f -----
hw/rtl/mf3_pkg.sv
hw/rtl/mf3_ram.sv
hw/rtl/max_filter_3x3.sv
dv/tb_max_filter_3x3.sv
